FILE: src/mdbp_pkg.sv
`default_nettype none

package mdbp_pkg;

    // field widths
    localparam int PIXEL_INDEX_BITS = 12;
    localparam int COORD_BITS       = 24;
    localparam int DEPTH_W          = 16;
    localparam int MASK_W           = 8;

    // fixed-point layout
    localparam int PRINCIPAL_W = 16;                   // unsigned Q12.4
    localparam int INV_FOCAL_W = 24;                   // unsigned Q0.24
    localparam int IDX_FRAC    = 4;
    localparam int FRAC_BITS   = 28;
    localparam int DIFF_W      = PRINCIPAL_W + 1;      // signed index minus principal
    localparam int MAG_W       = PRINCIPAL_W;
    localparam int P1_W        = MAG_W + DEPTH_W;
    localparam int P2_W        = P1_W + INV_FOCAL_W;
    localparam int QMAG_W      = P2_W - FRAC_BITS;

    // bounds registers: signed min in low half, signed max in high half
    localparam int BOUND_W  = 24;
    localparam int BOUNDS_W = 2 * BOUND_W;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = BOUNDS_W;

    localparam logic [CFG_ADDR_W-1:0] REG_MASK_MIN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_X = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_Y = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PRINCIPAL_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PRINCIPAL_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_X_BOUNDS    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_BOUNDS    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_Z_BOUNDS    = 3'd7;

    // reset values
    localparam logic [MASK_W-1:0]      RST_MASK_MIN    = 8'd128;
    localparam logic [INV_FOCAL_W-1:0] RST_INV_FOCAL   = 24'd27962;
    localparam logic [PRINCIPAL_W-1:0] RST_PRINCIPAL_X = 16'd5120;
    localparam logic [PRINCIPAL_W-1:0] RST_PRINCIPAL_Y = 16'd3840;
    localparam logic [BOUNDS_W-1:0]    RST_XY_BOUNDS   = 48'h0007D0_FFF830;
    localparam logic [BOUNDS_W-1:0]    RST_Z_BOUNDS    = 48'h000BB8_000064;

    // projection pipeline depth in register stages
    localparam int PROJ_STAGES = 4;

    // camera constants for one axis
    typedef struct packed {
        logic [PRINCIPAL_W-1:0] principal;
        logic [INV_FOCAL_W-1:0] inv_focal;
    } proj_cfg_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

`default_nettype wire

FILE: src/masked_depth_backprojection.sv
`default_nettype none

// Masked pinhole back-projection of a depth pixel stream. Each input transaction
// carries one pixel (column, row, raw depth, mask value, frame-end flag) and
// yields exactly one output transaction, in order. The pixel becomes a point when
// the mask is at least the mask_min register, the depth is nonzero and the floored,
// saturated x/y and the raw depth all fall inside the inclusive workspace box;
// otherwise tuser is 0 and the coordinates read zero, while tlast still follows
// the input. Coordinates are in raw depth units (x = (u - cx) * z / fx, using the
// Q12.4 principal point and Q0.24 reciprocal focal lengths). Throughput is one
// pixel per clock while the output is not stalled. There are five register
// stages: sign handling, the two multiplier stages of each axis, saturation and
// the box compare. The whole pipeline holds while the output is stalled.
// Registers are written through cfg_wr_en/cfg_addr/cfg_wdata and should change
// only while no pixel is in flight.

module masked_depth_backprojection (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // pixel input
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // column[11:0], pixel_row[23:12], depth_value[39:24], mask_value[47:40]
    input  wire logic [47:0]                        s_axis_tdata,
    input  wire logic                               s_axis_tlast,       // last_pixel

    // point output
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // coord_x[23:0], coord_y[47:24], coord_z[63:48]
    output logic [63:0]                             m_axis_tdata,
    output logic                                    m_axis_tuser,       // point_kept
    output logic                                    m_axis_tlast,       // frame_end

    // register writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [mdbp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [mdbp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import mdbp_pkg::*;

    // configuration registers
    logic [MASK_W-1:0]      mask_min_reg;
    logic [INV_FOCAL_W-1:0] inv_focal_x_reg;
    logic [INV_FOCAL_W-1:0] inv_focal_y_reg;
    logic [PRINCIPAL_W-1:0] principal_x_reg;
    logic [PRINCIPAL_W-1:0] principal_y_reg;
    logic [BOUNDS_W-1:0]    x_bounds_reg;
    logic [BOUNDS_W-1:0]    y_bounds_reg;
    logic [BOUNDS_W-1:0]    z_bounds_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_min_reg    <= RST_MASK_MIN;
            inv_focal_x_reg <= RST_INV_FOCAL;
            inv_focal_y_reg <= RST_INV_FOCAL;
            principal_x_reg <= RST_PRINCIPAL_X;
            principal_y_reg <= RST_PRINCIPAL_Y;
            x_bounds_reg    <= RST_XY_BOUNDS;
            y_bounds_reg    <= RST_XY_BOUNDS;
            z_bounds_reg    <= RST_Z_BOUNDS;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MASK_MIN:    mask_min_reg    <= cfg_wdata[MASK_W-1:0];
                REG_INV_FOCAL_X: inv_focal_x_reg <= cfg_wdata[INV_FOCAL_W-1:0];
                REG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_wdata[INV_FOCAL_W-1:0];
                REG_PRINCIPAL_X: principal_x_reg <= cfg_wdata[PRINCIPAL_W-1:0];
                REG_PRINCIPAL_Y: principal_y_reg <= cfg_wdata[PRINCIPAL_W-1:0];
                REG_X_BOUNDS:    x_bounds_reg    <= cfg_wdata[BOUNDS_W-1:0];
                REG_Y_BOUNDS:    y_bounds_reg    <= cfg_wdata[BOUNDS_W-1:0];
                REG_Z_BOUNDS:    z_bounds_reg    <= cfg_wdata[BOUNDS_W-1:0];
                default: ;
            endcase
        end
    end

    // input field unpacking
    logic [PIXEL_INDEX_BITS-1:0] in_column;
    logic [PIXEL_INDEX_BITS-1:0] in_row;
    logic [DEPTH_W-1:0]          in_depth;
    logic [MASK_W-1:0]           in_mask;

    assign in_column = s_axis_tdata[11:0];
    assign in_row    = s_axis_tdata[23:12];
    assign in_depth  = s_axis_tdata[39:24];
    assign in_mask   = s_axis_tdata[47:40];

    // one enable for every stage: advance unless the output holds an untaken transaction
    logic pipe_en;
    assign pipe_en       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = pipe_en;

    // valid bits and side data travelling alongside the projection units
    logic [PROJ_STAGES-1:0] valid_reg;
    logic [PROJ_STAGES-1:0] gate_reg;      // mask and nonzero depth test
    logic [PROJ_STAGES-1:0] last_reg;
    logic [DEPTH_W-1:0]     depth_reg [PROJ_STAGES];
    logic                   gate_next;

    assign gate_next = (in_mask >= mask_min_reg) && (in_depth != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[PROJ_STAGES-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            gate_reg     <= {gate_reg[PROJ_STAGES-2:0], gate_next};
            last_reg     <= {last_reg[PROJ_STAGES-2:0], s_axis_tlast};
            depth_reg[0] <= in_depth;
            for (int i = 1; i < PROJ_STAGES; i++) begin
                depth_reg[i] <= depth_reg[i-1];
            end
        end
    end

    // per-axis projection, PROJ_STAGES register stages deep
    proj_cfg_t cfg_x;
    proj_cfg_t cfg_y;
    coord_t    proj_x;
    coord_t    proj_y;

    assign cfg_x = '{principal: principal_x_reg, inv_focal: inv_focal_x_reg};
    assign cfg_y = '{principal: principal_y_reg, inv_focal: inv_focal_y_reg};

    mdbp_proj u_proj_x (
        .aclk  (aclk),
        .en    (pipe_en),
        .idx   (in_column),
        .depth (in_depth),
        .cfg   (cfg_x),
        .coord (proj_x)
    );

    mdbp_proj u_proj_y (
        .aclk  (aclk),
        .en    (pipe_en),
        .idx   (in_row),
        .depth (in_depth),
        .cfg   (cfg_y),
        .coord (proj_y)
    );

    // workspace box test, inclusive on both ends
    logic signed [BOUND_W-1:0] x_min, x_max, y_min, y_max, z_min, z_max;
    logic signed [BOUND_W:0]   z_val;
    logic                      kept_next;

    assign x_min = x_bounds_reg[BOUND_W-1:0];
    assign x_max = x_bounds_reg[BOUNDS_W-1:BOUND_W];
    assign y_min = y_bounds_reg[BOUND_W-1:0];
    assign y_max = y_bounds_reg[BOUNDS_W-1:BOUND_W];
    assign z_min = z_bounds_reg[BOUND_W-1:0];
    assign z_max = z_bounds_reg[BOUNDS_W-1:BOUND_W];
    assign z_val = {(BOUND_W + 1 - DEPTH_W)'(0), depth_reg[PROJ_STAGES-1]};

    assign kept_next = gate_reg[PROJ_STAGES-1]
                    && (proj_x >= x_min) && (proj_x <= x_max)
                    && (proj_y >= y_min) && (proj_y <= y_max)
                    && (z_val >= (BOUND_W + 1)'(z_min)) && (z_val <= (BOUND_W + 1)'(z_max));

    // output register
    logic        out_valid_reg;
    logic        out_kept_reg;
    logic        out_last_reg;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;

    assign out_data_next = kept_next ? {depth_reg[PROJ_STAGES-1], proj_y, proj_x} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= valid_reg[PROJ_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_kept_reg <= kept_next;
            out_last_reg <= last_reg[PROJ_STAGES-1];
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kept_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: src/mdbp_proj.sv
`default_nettype none

module mdbp_proj (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic [mdbp_pkg::PIXEL_INDEX_BITS-1:0] idx,
    input  wire logic [mdbp_pkg::DEPTH_W-1:0]        depth,
    input  wire mdbp_pkg::proj_cfg_t                 cfg,
    output mdbp_pkg::coord_t                         coord
);
    import mdbp_pkg::*;

    localparam logic [QMAG_W-1:0] POS_MAX = QMAG_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic [QMAG_W-1:0] NEG_MAG = QMAG_W'(64'd1 << (COORD_BITS - 1));
    localparam logic [P2_W-1:0]   ROUND_UP = P2_W'((64'd1 << FRAC_BITS) - 64'd1);

    // stage 1: signed offset from principal point, split into sign and magnitude
    logic [DIFF_W-1:0]  diff_next;
    logic [MAG_W-1:0]   mag_next;
    logic [MAG_W-1:0]   mag_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [2:0]         neg_reg;

    // stage 2 and 3: magnitude products
    logic [P1_W-1:0]    p1_reg;
    logic [P2_W-1:0]    p2_reg;

    // stage 4: floor shift and saturation
    logic [P2_W-1:0]    shifted_next;
    logic [QMAG_W-1:0]  qmag_next;
    coord_t             coord_next;
    coord_t             coord_reg;

    assign diff_next = {1'b0, idx, {IDX_FRAC{1'b0}}} - {1'b0, cfg.principal};
    assign mag_next  = diff_next[DIFF_W-1] ? MAG_W'(~diff_next + 1'b1) : diff_next[MAG_W-1:0];

    // negative offsets round the magnitude up so the signed result floors
    assign shifted_next = neg_reg[2] ? ((p2_reg + ROUND_UP) >> FRAC_BITS) : (p2_reg >> FRAC_BITS);
    assign qmag_next    = shifted_next[QMAG_W-1:0];

    always_comb begin
        if (!neg_reg[2]) begin
            coord_next = (qmag_next > POS_MAX) ? coord_t'(POS_MAX) : coord_t'(qmag_next);
        end else if (qmag_next > NEG_MAG) begin
            coord_next = coord_t'(NEG_MAG);
        end else begin
            coord_next = coord_t'(~qmag_next[COORD_BITS-1:0] + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg    <= mag_next;
            depth_reg  <= depth;
            neg_reg    <= {neg_reg[1:0], diff_next[DIFF_W-1]};
            p1_reg     <= mag_reg * depth_reg;
            p2_reg     <= p1_reg * cfg.inv_focal;
            coord_reg  <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

`default_nettype wire

FILE: src/mdbp_checker.sv
`default_nettype none

module mdbp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled output transaction holds its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // dropped pixels carry all-zero coordinates
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("dropped pixel with nonzero coordinates");

    // a kept point never has zero depth
    a_kept_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:48] != 16'd0)
        else $error("kept point with zero depth");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind masked_depth_backprojection mdbp_checker u_mdbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: sim/masked_depth_backprojection_test.sv
`timescale 1ns / 1ps

// Testbench for the masked depth back-projection block.
// A short directed table covers the mask threshold edges, zero depth, the z window edges,
// saturation, zero reciprocal focal length, inverted bounds and register width masking.
// It is followed by random pixels under several register setups, the all-zero and all-one
// extremes among them. Every output transaction is checked field by field against an
// in-order queue of predicted points. Both sides insert random idle cycles, and the
// output side holds off for a long stretch twice so that the pipeline backs up.

module masked_depth_backprojection_test;

    import mdbp_pkg::*;

    localparam int  CLK_PERIOD  = 10;
    localparam int  RST_CYCLES  = 10;
    localparam int  CYCLE_LIMIT = 300000;   // far beyond the slowest legal run
    localparam int  HOLD_CYCLES = 200;      // long output stall, fills the pipeline
    localparam int  N_EXTREME   = 60;       // pixels under each all-zero / all-one setup
    localparam int  N_RANDOM    = 156;      // pixels under each random setup
    localparam int  N_SETUPS    = 7;        // setup 0 all zeros, 1 all ones, rest random

    // one pixel as it enters
    typedef struct packed {
        logic [PIXEL_INDEX_BITS-1:0] col;
        logic [PIXEL_INDEX_BITS-1:0] row;
        logic [DEPTH_W-1:0]          depth;
        logic [MASK_W-1:0]           mask;
        logic                        last;
    } pixel_t;

    // one point as it leaves
    typedef struct packed {
        logic                  kept;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DEPTH_W-1:0]    z;
        logic                  fend;
    } point_t;

    // directed row: either a register write or a pixel, optionally with a typed-in point
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
        pixel_t                px;
        logic                  typed;
        point_t                want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [63:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // register shadow used by the predictor
    logic [MASK_W-1:0]      thr_cfg;
    logic [INV_FOCAL_W-1:0] ifx_cfg;
    logic [INV_FOCAL_W-1:0] ify_cfg;
    logic [PRINCIPAL_W-1:0] ppx_cfg;
    logic [PRINCIPAL_W-1:0] ppy_cfg;
    logic [BOUNDS_W-1:0]    xb_cfg;
    logic [BOUNDS_W-1:0]    yb_cfg;
    logic [BOUNDS_W-1:0]    zb_cfg;

    point_t   pending_points[$];
    dir_row_t dir_rows[$];
    int       n_sent   = 0;
    int       n_points = 0;
    int       n_errors = 0;
    int       cycles   = 0;
    bit       quiet_tx = 1'b0;
    bit       quiet_rx = 1'b0;

    masked_depth_backprojection u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL masked_depth_backprojection");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    // one axis: (index*16 - principal) * depth * inv_focal, floored by 2^28, saturated
    function automatic longint backproject_axis(logic [PIXEL_INDEX_BITS-1:0] idx,
                                                logic [PRINCIPAL_W-1:0] pp,
                                                logic [INV_FOCAL_W-1:0] inv_f,
                                                logic [DEPTH_W-1:0] depth);
        longint          scaled;
        longint          centre;
        longint          diff;
        longint unsigned mag;
        longint unsigned prod;
        longint          q;
        longint          hi;
        scaled = longint'({idx, 4'd0});
        centre = longint'(pp);
        diff   = scaled - centre;
        mag    = (diff < 0) ? -diff : diff;
        prod   = mag * depth * inv_f;
        // floor toward minus infinity: round the magnitude up when negative
        if (diff < 0)
            q = -longint'((prod + ((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS);
        else
            q = longint'(prod >> FRAC_BITS);
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
        if (q > hi) q = hi;
        if (q < -hi - 1) q = -hi - 1;
        return q;
    endfunction

    // inclusive window check, signed min in the low half and signed max in the high half
    function automatic bit in_window(longint v, logic [BOUNDS_W-1:0] b);
        logic signed [BOUND_W-1:0] lo24;
        logic signed [BOUND_W-1:0] hi24;
        longint                    lo;
        longint                    hi;
        lo24 = b[BOUND_W-1:0];
        hi24 = b[BOUNDS_W-1:BOUND_W];
        lo   = longint'(lo24);
        hi   = longint'(hi24);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic point_t project_pixel(pixel_t px);
        point_t pt;
        longint x;
        longint y;
        pt      = '0;
        pt.fend = px.last;
        if (px.mask >= thr_cfg && px.depth != 0) begin
            x = backproject_axis(px.col, ppx_cfg, ifx_cfg, px.depth);
            y = backproject_axis(px.row, ppy_cfg, ify_cfg, px.depth);
            if (in_window(x, xb_cfg) && in_window(y, yb_cfg) &&
                in_window(longint'(px.depth), zb_cfg)) begin
                pt.kept = 1'b1;
                pt.x    = x[COORD_BITS-1:0];
                pt.y    = y[COORD_BITS-1:0];
                pt.z    = px.depth;
            end
        end
        return pt;
    endfunction

    // ---------------------------------------------------------------- table rows

    function automatic pixel_t mk_pixel(int col, int row, int depth, int mask, int last);
        pixel_t px;
        px.col   = col[PIXEL_INDEX_BITS-1:0];
        px.row   = row[PIXEL_INDEX_BITS-1:0];
        px.depth = depth[DEPTH_W-1:0];
        px.mask  = mask[MASK_W-1:0];
        px.last  = last[0];
        return px;
    endfunction

    function automatic dir_row_t pix(int col, int row, int depth, int mask, int last);
        dir_row_t r;
        r    = '0;
        r.px = mk_pixel(col, row, depth, mask, last);
        return r;
    endfunction

    // pixel whose point is typed in; a dropped point has kept, x, y and z all zero
    function automatic dir_row_t pix_exp(int col, int row, int depth, int mask, int last,
                                         int kept, int x, int y, int z);
        dir_row_t r;
        r           = pix(col, row, depth, mask, last);
        r.typed     = 1'b1;
        r.want.kept = kept[0];
        r.want.x    = x[COORD_BITS-1:0];
        r.want.y    = y[COORD_BITS-1:0];
        r.want.z    = z[DEPTH_W-1:0];
        r.want.fend = last[0];
        return r;
    endfunction

    function automatic dir_row_t setreg(logic [CFG_ADDR_W-1:0] addr,
                                        logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r        = '0;
        r.is_reg = 1'b1;
        r.addr   = addr;
        r.wdata  = data;
        return r;
    endfunction

    function automatic logic [BOUNDS_W-1:0] span(int lo, int hi);
        return {hi[BOUND_W-1:0], lo[BOUND_W-1:0]};
    endfunction

    // ---------------------------------------------------------------- drivers

    // register write at one rising edge, shadow updated with the block's masking
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(posedge aclk);
        case (addr)
            REG_MASK_MIN:    thr_cfg = data[MASK_W-1:0];
            REG_INV_FOCAL_X: ifx_cfg = data[INV_FOCAL_W-1:0];
            REG_INV_FOCAL_Y: ify_cfg = data[INV_FOCAL_W-1:0];
            REG_PRINCIPAL_X: ppx_cfg = data[PRINCIPAL_W-1:0];
            REG_PRINCIPAL_Y: ppy_cfg = data[PRINCIPAL_W-1:0];
            REG_X_BOUNDS:    xb_cfg  = data;
            REG_Y_BOUNDS:    yb_cfg  = data;
            REG_Z_BOUNDS:    zb_cfg  = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // stop offering and let every point in flight drain out
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // offer one pixel after a random gap; called and returning at a falling edge
    task automatic send_pixel(input pixel_t px, input logic typed, input point_t want);
        int gap;
        if (n_sent % 50 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
        gap = quiet_tx ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  = {px.mask, px.depth, px.row, px.col};
        s_axis_tlast  = px.last;
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_points.insert(pending_points.size(), typed ? want : project_pixel(px));
        n_sent++;
        @(negedge aclk);
    endtask

    // one register setup per random phase; narrow registers get junk in the upper bits
    task automatic load_setup(input int kind);
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] fill;
        int                    sel;
        if (kind < 2) begin
            // all-zero and all-one extremes
            fill = (kind == 0) ? '0 : '1;
            write_reg(REG_MASK_MIN, fill);
            write_reg(REG_INV_FOCAL_X, fill);
            write_reg(REG_INV_FOCAL_Y, fill);
            write_reg(REG_PRINCIPAL_X, fill);
            write_reg(REG_PRINCIPAL_Y, fill);
            write_reg(REG_X_BOUNDS, fill);
            write_reg(REG_Y_BOUNDS, fill);
            write_reg(REG_Z_BOUNDS, fill);
        end else begin
            junk = CFG_DATA_W'({$urandom, $urandom});
            write_reg(REG_MASK_MIN, {junk[47:8], 8'($urandom_range(0, 255))});
            for (int a = 0; a < 2; a++) begin
                junk = CFG_DATA_W'({$urandom, $urandom});
                sel  = $urandom_range(0, 7);
                case (sel)
                    0:       fill = '0;
                    1:       fill = 48'hFFFFFF;
                    2:       fill = CFG_DATA_W'(24'($urandom));
                    default: fill = CFG_DATA_W'(24'($urandom_range(8000, 60000)));
                endcase
                write_reg(a == 0 ? REG_INV_FOCAL_X : REG_INV_FOCAL_Y,
                          {junk[47:24], fill[23:0]});
                junk = CFG_DATA_W'({$urandom, $urandom});
                write_reg(a == 0 ? REG_PRINCIPAL_X : REG_PRINCIPAL_Y,
                          {junk[47:16], 16'($urandom_range(0, 65535))});
                sel = $urandom_range(0, 7);
                case (sel)
                    0:       fill = span($urandom_range(0, 5000), -int'($urandom_range(0, 5000)));
                    1:       fill = CFG_DATA_W'({$urandom, $urandom});
                    default: fill = span(-int'($urandom_range(0, 40000)),
                                         $urandom_range(0, 40000));
                endcase
                write_reg(a == 0 ? REG_X_BOUNDS : REG_Y_BOUNDS, fill);
            end
            sel = $urandom_range(0, 7);
            case (sel)
                0:       fill = span(-int'($urandom_range(0, 100)), $urandom_range(0, 65535));
                1:       fill = span($urandom_range(3000, 9000), $urandom_range(0, 2000));
                default: fill = span($urandom_range(0, 2000), $urandom_range(2000, 65535));
            endcase
            write_reg(REG_Z_BOUNDS, fill);
        end
    endtask

    function automatic pixel_t random_pixel();
        pixel_t px;
        int     sel;
        px.col = PIXEL_INDEX_BITS'($urandom_range(0, 4095));
        px.row = PIXEL_INDEX_BITS'($urandom_range(0, 4095));
        sel    = $urandom_range(0, 15);
        case (sel)
            0:       px.depth = '0;
            1, 2:    px.depth = DEPTH_W'($urandom_range(0, 65535));
            default: px.depth = DEPTH_W'($urandom_range(1, 8000));
        endcase
        // mostly at or above the threshold so the projection gets exercised
        if ($urandom_range(0, 3) != 0)
            px.mask = MASK_W'($urandom_range(thr_cfg, 255));
        else
            px.mask = MASK_W'($urandom_range(0, 255));
        px.last = ($urandom_range(0, 15) == 0);
        return px;
    endfunction

    // ---------------------------------------------------------------- output side

    task automatic check_point();
        point_t want;
        if (pending_points.size() == 0) begin
            $error("unexpected output transaction: tdata %h", m_axis_tdata);
            n_errors++;
            return;
        end
        want = pending_points.pop_front();
        if (m_axis_tuser !== want.kept) begin
            $error("point_kept: expected %0d, got %0d", want.kept, m_axis_tuser);
            n_errors++;
        end
        if (m_axis_tdata[23:0] !== want.x) begin
            $error("coord_x: expected %0d, got %0d", $signed(want.x),
                   $signed(m_axis_tdata[23:0]));
            n_errors++;
        end
        if (m_axis_tdata[47:24] !== want.y) begin
            $error("coord_y: expected %0d, got %0d", $signed(want.y),
                   $signed(m_axis_tdata[47:24]));
            n_errors++;
        end
        if (m_axis_tdata[63:48] !== want.z) begin
            $error("coord_z: expected %0d, got %0d", want.z, m_axis_tdata[63:48]);
            n_errors++;
        end
        if (m_axis_tlast !== want.fend) begin
            $error("frame_end: expected %0d, got %0d", want.fend, m_axis_tlast);
            n_errors++;
        end
    endtask

    // random ready stalls; two long hold-offs while the input side keeps offering
    initial begin : point_sink
        int w;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (n_points % 50 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
            w = quiet_rx ? 0 : $urandom_range(0, 3);
            if (n_points == 400 || n_points == 650) w = HOLD_CYCLES;
            if (w > 0) begin
                m_axis_tready = 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            check_point();
            n_points++;
            @(negedge aclk);
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : pixel_source
        int     n_items;
        pixel_t px;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;

        thr_cfg = RST_MASK_MIN;
        ifx_cfg = RST_INV_FOCAL;
        ify_cfg = RST_INV_FOCAL;
        ppx_cfg = RST_PRINCIPAL_X;
        ppy_cfg = RST_PRINCIPAL_Y;
        xb_cfg  = RST_XY_BOUNDS;
        yb_cfg  = RST_XY_BOUNDS;
        zb_cfg  = RST_Z_BOUNDS;

        // the principal point after reset is pixel (320, 240), so x and y read zero there
        dir_rows = '{
            // threshold edge, zero depth and the z window edges under reset values
            pix_exp(320, 240, 1000, 128, 0, 1, 0, 0, 1000),
            pix_exp(320, 240, 1000, 127, 0, 0, 0, 0, 0),
            pix_exp(320, 240, 0, 255, 1, 0, 0, 0, 0),
            pix_exp(320, 240, 99, 255, 0, 0, 0, 0, 0),
            pix_exp(320, 240, 100, 255, 1, 1, 0, 0, 100),
            pix_exp(320, 240, 3000, 200, 0, 1, 0, 0, 3000),
            pix_exp(320, 240, 3001, 200, 0, 0, 0, 0, 0),
            pix(0, 0, 1000, 255, 0),
            pix(4095, 4095, 65535, 255, 1),
            pix(639, 479, 2500, 255, 0),
            // widest box and largest reciprocal focal: x saturates both ways
            setreg(REG_Z_BOUNDS, 48'h7FFFFF_800000),
            setreg(REG_X_BOUNDS, 48'h7FFFFF_800000),
            setreg(REG_Y_BOUNDS, 48'h7FFFFF_800000),
            setreg(REG_INV_FOCAL_X, 48'h000000_FFFFFF),
            pix(4095, 0, 65535, 255, 0),
            pix(0, 4095, 65535, 255, 0),
            // zero reciprocal focal flattens y
            setreg(REG_INV_FOCAL_Y, 48'h0),
            pix_exp(320, 4095, 500, 255, 0, 1, 0, 0, 500),
            // inverted x window: min 10, max -10
            setreg(REG_X_BOUNDS, 48'hFFFFF6_00000A),
            pix_exp(320, 4095, 500, 255, 1, 0, 0, 0, 0),
            setreg(REG_MASK_MIN, 48'h0),
            setreg(REG_X_BOUNDS, 48'h7FFFFF_800000),
            pix_exp(320, 100, 7, 0, 0, 1, 0, 0, 7),
            // upper junk bits must be dropped, threshold becomes 255
            setreg(REG_MASK_MIN, 48'hABCDEF_1234FF),
            pix_exp(320, 0, 7, 254, 0, 0, 0, 0, 0),
            pix_exp(320, 0, 7, 255, 0, 1, 0, 0, 7),
            setreg(REG_PRINCIPAL_X, 48'hFFFF_FFFF_FFFF),
            setreg(REG_PRINCIPAL_Y, 48'h0),
            pix(4095, 4095, 65535, 255, 1),
            pix(0, 0, 1, 255, 0),
            setreg(REG_INV_FOCAL_X, 48'h123456_000001),
            setreg(REG_INV_FOCAL_Y, 48'h000000_800000),
            pix(2048, 2048, 32768, 255, 0),
            pix(4095, 1, 65535, 255, 1)
        };

        repeat (RST_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                wait_idle();
                write_reg(dir_rows[i].addr, dir_rows[i].wdata);
            end else begin
                send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // random phases, each under its own register setup
        for (int s = 0; s < N_SETUPS; s++) begin
            wait_idle();
            load_setup(s);
            n_items = (s < 2) ? N_EXTREME : N_RANDOM;
            for (int k = 0; k < n_items; k++) begin
                px = random_pixel();
                send_pixel(px, 1'b0, '0);
            end
        end

        s_axis_tvalid = 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        // catch any stray transaction after the last expected one
        repeat (PROJ_STAGES + 16) @(posedge aclk);

        if (n_errors == 0) begin
            $display("PASS masked_depth_backprojection");
        end else begin
            $display("FAIL masked_depth_backprojection");
        end
        $finish;
    end

endmodule
